@@ design/clts_pkg.sv @@
`timescale 1ns / 1ps

package clts_pkg;

    localparam int VALUE_W     = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int BITS_W      = $clog2(VALUE_W + 1);
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int UPC_W       = 5;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef logic [UPC_W-1:0] upc_t;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CHAR   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_NUMBER = 2'd3;

    // request status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TWO_LINES    = 3'd0;
    localparam logic [2:0] REG_LARGE_FONT   = 3'd1;
    localparam logic [2:0] REG_DISPLAY_ON   = 3'd2;
    localparam logic [2:0] REG_CURSOR_ON    = 3'd3;
    localparam logic [2:0] REG_CURSOR_BLINK = 3'd4;

    // lcd commands
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_BASE = 8'h08;
    localparam logic [7:0] CMD_FUNC_BASE = 8'h30;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;

    // init offsets after the power-up delay
    localparam logic [3:0] OFF_HOME       = 4'd0;
    localparam logic [3:0] OFF_HOME_LOW   = 4'd1;
    localparam logic [3:0] OFF_FUNC       = 4'd2;
    localparam logic [3:0] OFF_FUNC_LOW   = 4'd3;
    localparam logic [3:0] OFF_DISP       = 4'd4;
    localparam logic [3:0] OFF_DISP_LOW   = 4'd5;
    localparam logic [3:0] OFF_CLEAR      = 4'd6;
    localparam logic [3:0] OFF_CLEAR_LOW  = 4'd7;
    localparam logic [3:0] OFF_ENTRY      = 4'd9;
    localparam logic [3:0] OFF_DONE       = 4'd10;

    // request phases
    localparam logic [2:0] CLEAR_PH_CMD    = 3'd0;
    localparam logic [2:0] CLEAR_PH_LOW    = 3'd2;
    localparam logic [2:0] CLEAR_PH_LAST   = 3'd4;
    localparam logic [2:0] NUM_PH_CONVERT  = 3'd0;
    localparam logic [2:0] NUM_PH_EMIT     = 3'd1;
    localparam logic [2:0] NUM_PH_END      = 3'd2;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_STRING = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NUMBER = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        CLS_INIT       = 4'd0,
        CLS_REJECT     = 4'd1,
        CLS_CHAR       = 4'd2,
        CLS_CLEAR_REQ  = 4'd3,
        CLS_NUM_REQ    = 4'd4,
        CLS_IDLE       = 4'd5,
        CLS_STRING     = 4'd6,
        CLS_CLEAR_TICK = 4'd7,
        CLS_CONVERT    = 4'd8,
        CLS_EMIT       = 4'd9,
        CLS_FINISH     = 4'd10
    } item_class_t;

    typedef enum logic [2:0] {
        COND_NEXT         = 3'd0,
        COND_ALWAYS       = 3'd1,
        COND_NO_ITEM      = 3'd2,
        COND_DISPATCH     = 3'd3,
        COND_BITS_LEFT    = 3'd4,
        COND_NO_LEAD_ZERO = 3'd5,
        COND_OUT_BLOCKED  = 3'd6
    } cond_t;

    typedef struct packed {
        cond_t cond;
        upc_t  target;
        logic  accept;
        logic  st_reject;
        logic  st_accept;
        logic  init_step;
        logic  char_write;
        logic  start_clear;
        logic  start_number;
        logic  char_read;
        logic  string_emit;
        logic  clear_step;
        logic  dd_load;
        logic  dd_step;
        logic  dig_init;
        logic  dig_strip;
        logic  digit_emit;
        logic  num_end;
        logic  out_write;
    } ctl_word_t;

    typedef struct packed {
        item_class_t cls;
        logic        bits_left;
        logic        lead_zero;
    } dp_flags_t;

    typedef struct packed {
        logic two_lines;
        logic large_font;
        logic display_on;
        logic cursor_on;
        logic cursor_blink;
    } cfg_t;

    typedef struct packed {
        logic       bus_write;
        logic       register_select;
        logic [7:0] bus_byte;
        logic       enable_pulsed;
        logic       enable_level;
        logic       busy;
        logic       operational;
        logic [1:0] status;
    } res_t;

    // microprogram addresses
    localparam upc_t UPC_OUT        = 5'd0;
    localparam upc_t UPC_IDLE       = 5'd1;
    localparam upc_t UPC_DISPATCH   = 5'd2;
    localparam upc_t UPC_REJECT     = 5'd3;
    localparam upc_t UPC_INIT       = 5'd4;
    localparam upc_t UPC_CHAR       = 5'd5;
    localparam upc_t UPC_CLEAR_REQ  = 5'd6;
    localparam upc_t UPC_NUM_REQ    = 5'd7;
    localparam upc_t UPC_STR_READ   = 5'd8;
    localparam upc_t UPC_STR_EMIT   = 5'd9;
    localparam upc_t UPC_CLEAR_TICK = 5'd10;
    localparam upc_t UPC_CONV_LOAD  = 5'd11;
    localparam upc_t UPC_CONV_STEP  = 5'd12;
    localparam upc_t UPC_CONV_FIX   = 5'd13;
    localparam upc_t UPC_CONV_CHECK = 5'd14;
    localparam upc_t UPC_CONV_STRIP = 5'd15;
    localparam upc_t UPC_EMIT       = 5'd16;
    localparam upc_t UPC_FINISH     = 5'd17;

    function automatic ctl_word_t ucode_rom(input upc_t addr);
        ctl_word_t w;
        w = '0;
        w.cond = COND_ALWAYS;
        w.target = UPC_OUT;
        case (addr)
            UPC_OUT:
            begin
                w.cond = COND_OUT_BLOCKED;
                w.target = UPC_OUT;
                w.out_write = 1'b1;
            end
            UPC_IDLE:
            begin
                w.cond = COND_NO_ITEM;
                w.target = UPC_IDLE;
                w.accept = 1'b1;
            end
            UPC_DISPATCH:
            begin
                w.cond = COND_DISPATCH;
            end
            UPC_REJECT:     w.st_reject = 1'b1;
            UPC_INIT:       w.init_step = 1'b1;
            UPC_CHAR:
            begin
                w.st_accept = 1'b1;
                w.char_write = 1'b1;
            end
            UPC_CLEAR_REQ:
            begin
                w.st_accept = 1'b1;
                w.start_clear = 1'b1;
            end
            UPC_NUM_REQ:
            begin
                w.st_accept = 1'b1;
                w.start_number = 1'b1;
            end
            UPC_STR_READ:
            begin
                w.cond = COND_NEXT;
                w.char_read = 1'b1;
            end
            UPC_STR_EMIT:   w.string_emit = 1'b1;
            UPC_CLEAR_TICK: w.clear_step = 1'b1;
            UPC_CONV_LOAD:
            begin
                w.cond = COND_NEXT;
                w.dd_load = 1'b1;
            end
            UPC_CONV_STEP:
            begin
                w.cond = COND_BITS_LEFT;
                w.target = UPC_CONV_STEP;
                w.dd_step = 1'b1;
            end
            UPC_CONV_FIX:
            begin
                w.cond = COND_NEXT;
                w.dig_init = 1'b1;
            end
            UPC_CONV_CHECK:
            begin
                w.cond = COND_NO_LEAD_ZERO;
                w.target = UPC_OUT;
            end
            UPC_CONV_STRIP:
            begin
                w.target = UPC_CONV_CHECK;
                w.dig_strip = 1'b1;
            end
            UPC_EMIT:       w.digit_emit = 1'b1;
            UPC_FINISH:     w.num_end = 1'b1;
            default:        w.target = UPC_IDLE;
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch_addr(input item_class_t cls);
        upc_t a;
        case (cls)
            CLS_INIT:       a = UPC_INIT;
            CLS_REJECT:     a = UPC_REJECT;
            CLS_CHAR:       a = UPC_CHAR;
            CLS_CLEAR_REQ:  a = UPC_CLEAR_REQ;
            CLS_NUM_REQ:    a = UPC_NUM_REQ;
            CLS_STRING:     a = UPC_STR_READ;
            CLS_CLEAR_TICK: a = UPC_CLEAR_TICK;
            CLS_CONVERT:    a = UPC_CONV_LOAD;
            CLS_EMIT:       a = UPC_EMIT;
            CLS_FINISH:     a = UPC_FINISH;
            default:        a = UPC_OUT;
        endcase
        return a;
    endfunction

endpackage

@@ design/clts_cfg.sv @@
`timescale 1ns / 1ps

module clts_cfg
    import clts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_index;
    logic       rd_bit;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_TWO_LINES:    cfg_next.two_lines    = pwdata[0];
                REG_LARGE_FONT:   cfg_next.large_font   = pwdata[0];
                REG_DISPLAY_ON:   cfg_next.display_on   = pwdata[0];
                REG_CURSOR_ON:    cfg_next.cursor_on    = pwdata[0];
                REG_CURSOR_BLINK: cfg_next.cursor_blink = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_TWO_LINES:    rd_bit = cfg_reg.two_lines;
            REG_LARGE_FONT:   rd_bit = cfg_reg.large_font;
            REG_DISPLAY_ON:   rd_bit = cfg_reg.display_on;
            REG_CURSOR_ON:    rd_bit = cfg_reg.cursor_on;
            REG_CURSOR_BLINK: rd_bit = cfg_reg.cursor_blink;
            default:          rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-1){1'b0}}, rd_bit};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.two_lines    <= 1'b1;
            cfg_reg.large_font   <= 1'b0;
            cfg_reg.display_on   <= 1'b1;
            cfg_reg.cursor_on    <= 1'b0;
            cfg_reg.cursor_blink <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/clts_seq.sv @@
`timescale 1ns / 1ps

module clts_seq
    import clts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_blocked,
    input  dp_flags_t flags,
    output ctl_word_t ctl
);

    upc_t upc_reg;
    upc_t upc_next;
    upc_t upc_inc;

    assign ctl     = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    always_comb
    begin
        case (ctl.cond)
            COND_NEXT:         upc_next = upc_inc;
            COND_ALWAYS:       upc_next = ctl.target;
            COND_NO_ITEM:      upc_next = in_valid ? upc_inc : ctl.target;
            COND_DISPATCH:     upc_next = dispatch_addr(flags.cls);
            COND_BITS_LEFT:    upc_next = flags.bits_left ? ctl.target : upc_inc;
            COND_NO_LEAD_ZERO: upc_next = flags.lead_zero ? upc_inc : ctl.target;
            COND_OUT_BLOCKED:  upc_next = out_blocked ? ctl.target : upc_inc;
            default:           upc_next = UPC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ design/clts_dp.sv @@
`timescale 1ns / 1ps

module clts_dp
    import clts_pkg::*;
#(
    parameter int STRING_DEPTH     = 32,
    parameter int INIT_DELAY_TICKS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_word_t          ctl,
    input  cfg_t               cfg,
    input  logic               in_valid,
    input  logic [1:0]         operation,
    input  logic [VALUE_W-1:0] value,
    input  logic               last_char,
    output dp_flags_t          flags,
    output res_t               res
);

    localparam int CW = $clog2(STRING_DEPTH + 1);
    localparam int AW = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;
    localparam int IW = $clog2(INIT_DELAY_TICKS + 11);

    logic [7:0] char_mem [0:STRING_DEPTH-1];
    logic [7:0] char_q_reg;

    logic [1:0]             op_reg, op_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic                   last_reg, last_next;

    logic                   operational_reg, operational_next;
    logic [IW-1:0]          init_ticks_reg, init_ticks_next;
    kind_t                  kind_reg, kind_next;
    logic                   busy_reg, busy_next;
    logic [2:0]             phase_reg, phase_next;
    logic [CW-1:0]          char_count_reg, char_count_next;
    logic [CW-1:0]          char_index_reg, char_index_next;
    logic [VALUE_W-1:0]     number_reg, number_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BITS_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] digit_count_reg, digit_count_next;
    logic                   enable_reg, enable_next;

    logic                   res_write_reg, res_write_next;
    logic                   res_rs_reg, res_rs_next;
    logic [7:0]             res_byte_reg, res_byte_next;
    logic                   res_pulse_reg, res_pulse_next;
    logic [1:0]             res_status_reg, res_status_next;

    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             dd_digit;
    logic [3:0]             top_digit;
    logic [IW-1:0]          init_off_full;
    logic [3:0]             init_off;
    logic                   string_more;
    logic                   finish;
    logic                   mem_we;
    logic                   mem_re;
    item_class_t            cls;

    assign top_digit     = bcd_reg[BCD_W-1 -: 4];
    assign init_off_full = init_ticks_reg - IW'(INIT_DELAY_TICKS);
    assign init_off      = init_off_full[3:0];
    assign string_more   = char_index_reg < char_count_reg;

    // add-3 adjust of every bcd digit
    always_comb
    begin
        dd_digit = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            dd_digit = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (dd_digit >= 4'd5) ? dd_digit + 4'd3 : dd_digit;
        end
    end

    always_comb
    begin
        if (op_reg == OP_TICK)
        begin
            if (!operational_reg)
                cls = CLS_INIT;
            else if (!busy_reg)
                cls = CLS_IDLE;
            else
            begin
                case (kind_reg)
                    KIND_STRING: cls = CLS_STRING;
                    KIND_CLEAR:  cls = CLS_CLEAR_TICK;
                    KIND_NUMBER:
                    begin
                        if (phase_reg == NUM_PH_CONVERT)
                            cls = CLS_CONVERT;
                        else if (phase_reg == NUM_PH_EMIT)
                            cls = CLS_EMIT;
                        else
                            cls = CLS_FINISH;
                    end
                    default:     cls = CLS_FINISH;
                endcase
            end
        end
        else if (!operational_reg || busy_reg)
            cls = CLS_REJECT;
        else if (op_reg == OP_CHAR)
            cls = CLS_CHAR;
        else if (op_reg == OP_CLEAR)
            cls = CLS_CLEAR_REQ;
        else
            cls = CLS_NUM_REQ;
    end

    assign flags.cls       = cls;
    assign flags.bits_left = bit_cnt_reg != BITS_W'(1);
    assign flags.lead_zero = (top_digit == 4'd0) && (digit_count_reg > DIGIT_CNT_W'(1));

    assign finish = ctl.start_clear | ctl.start_number | ctl.num_end
                  | (ctl.string_emit & ~string_more)
                  | (ctl.clear_step & (phase_reg >= CLEAR_PH_LAST));

    always_comb
    begin
        op_next          = op_reg;
        value_next       = value_reg;
        last_next        = last_reg;
        operational_next = operational_reg;
        init_ticks_next  = init_ticks_reg;
        kind_next        = kind_reg;
        busy_next        = busy_reg;
        phase_next       = phase_reg;
        char_count_next  = char_count_reg;
        char_index_next  = char_index_reg;
        number_next      = number_reg;
        bcd_next         = bcd_reg;
        bit_cnt_next     = bit_cnt_reg;
        digit_count_next = digit_count_reg;
        enable_next      = enable_reg;
        res_write_next   = res_write_reg;
        res_rs_next      = res_rs_reg;
        res_byte_next    = res_byte_reg;
        res_pulse_next   = res_pulse_reg;
        res_status_next  = res_status_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        if (ctl.accept && in_valid)
        begin
            op_next         = operation;
            value_next      = value;
            last_next       = last_char;
            res_write_next  = 1'b0;
            res_rs_next     = 1'b0;
            res_byte_next   = 8'h00;
            res_pulse_next  = 1'b0;
            res_status_next = STATUS_NONE;
        end

        if (ctl.st_reject)
            res_status_next = STATUS_REJECTED;
        if (ctl.st_accept)
            res_status_next = STATUS_ACCEPTED;

        // power-up command sequence
        if (ctl.init_step)
        begin
            if (init_ticks_reg >= IW'(INIT_DELAY_TICKS))
            begin
                case (init_off)
                    OFF_HOME:
                    begin
                        res_write_next = 1'b1;
                        res_byte_next  = CMD_HOME;
                        enable_next    = 1'b1;
                    end
                    OFF_FUNC:
                    begin
                        res_write_next = 1'b1;
                        res_byte_next  = CMD_FUNC_BASE | {4'd0, cfg.two_lines,
                                                          cfg.large_font, 2'd0};
                        enable_next    = 1'b1;
                    end
                    OFF_DISP:
                    begin
                        res_write_next = 1'b1;
                        res_byte_next  = CMD_DISP_BASE | {5'd0, cfg.display_on,
                                                          cfg.cursor_on, cfg.cursor_blink};
                        enable_next    = 1'b1;
                    end
                    OFF_CLEAR:
                    begin
                        res_write_next = 1'b1;
                        res_byte_next  = CMD_CLEAR;
                        enable_next    = 1'b1;
                    end
                    OFF_ENTRY:
                    begin
                        res_write_next = 1'b1;
                        res_byte_next  = CMD_ENTRY;
                        enable_next    = 1'b1;
                    end
                    OFF_HOME_LOW, OFF_FUNC_LOW, OFF_DISP_LOW, OFF_CLEAR_LOW:
                    begin
                        enable_next = 1'b0;
                    end
                    OFF_DONE:
                    begin
                        enable_next      = 1'b0;
                        operational_next = 1'b1;
                    end
                    default:
                    begin
                        enable_next = enable_reg;
                    end
                endcase
            end
            if (!operational_next)
                init_ticks_next = init_ticks_reg + 1'b1;
        end

        if (finish)
        begin
            busy_next        = 1'b0;
            kind_next        = KIND_NONE;
            phase_next       = 3'd0;
            char_count_next  = '0;
            char_index_next  = '0;
            digit_count_next = '0;
        end

        // string load
        if (ctl.char_write)
        begin
            if (char_count_reg < CW'(STRING_DEPTH))
            begin
                mem_we          = 1'b1;
                char_count_next = char_count_reg + 1'b1;
            end
            if (last_reg)
            begin
                kind_next       = KIND_STRING;
                busy_next       = 1'b1;
                char_index_next = '0;
                phase_next      = 3'd0;
            end
        end

        if (ctl.start_clear)
        begin
            kind_next = KIND_CLEAR;
            busy_next = 1'b1;
        end

        if (ctl.start_number)
        begin
            number_next = value_reg;
            kind_next   = KIND_NUMBER;
            busy_next   = 1'b1;
        end

        if (ctl.char_read)
            mem_re = string_more;

        if (ctl.string_emit && string_more)
        begin
            res_write_next  = 1'b1;
            res_rs_next     = 1'b1;
            res_byte_next   = char_q_reg;
            res_pulse_next  = 1'b1;
            enable_next     = 1'b0;
            char_index_next = char_index_reg + 1'b1;
        end

        // clear request ticks
        if (ctl.clear_step)
        begin
            if (phase_reg == CLEAR_PH_CMD)
            begin
                res_write_next = 1'b1;
                res_byte_next  = CMD_CLEAR;
                enable_next    = 1'b1;
            end
            else if (phase_reg == CLEAR_PH_LOW)
                enable_next = 1'b0;
            if (phase_reg < CLEAR_PH_LAST)
                phase_next = phase_reg + 1'b1;
        end

        // binary to bcd, one bit per cycle
        if (ctl.dd_load)
        begin
            bcd_next     = '0;
            bit_cnt_next = BITS_W'(VALUE_W);
        end

        if (ctl.dd_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], number_reg[VALUE_W-1]};
            number_next  = {number_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        if (ctl.dig_init)
        begin
            digit_count_next = DIGIT_CNT_W'(MAX_DIGITS);
            phase_next       = NUM_PH_EMIT;
        end

        if (ctl.dig_strip)
        begin
            bcd_next         = {bcd_reg[BCD_W-5:0], 4'd0};
            digit_count_next = digit_count_reg - 1'b1;
        end

        if (ctl.digit_emit)
        begin
            res_write_next   = 1'b1;
            res_rs_next      = 1'b1;
            res_byte_next    = ASCII_ZERO | {4'd0, top_digit};
            res_pulse_next   = 1'b1;
            enable_next      = 1'b0;
            bcd_next         = {bcd_reg[BCD_W-5:0], 4'd0};
            digit_count_next = digit_count_reg - 1'b1;
            if (digit_count_reg == DIGIT_CNT_W'(1))
                phase_next = NUM_PH_END;
        end

        if (ctl.num_end)
            number_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            char_mem[char_count_reg[AW-1:0]] <= value_reg[7:0];
        if (mem_re)
            char_q_reg <= char_mem[char_index_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        last_reg     <= last_next;
        number_reg   <= number_next;
        bcd_reg      <= bcd_next;
        res_byte_reg <= res_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= OP_TICK;
            operational_reg <= 1'b0;
            init_ticks_reg  <= '0;
            kind_reg        <= KIND_NONE;
            busy_reg        <= 1'b0;
            phase_reg       <= 3'd0;
            char_count_reg  <= '0;
            char_index_reg  <= '0;
            bit_cnt_reg     <= '0;
            digit_count_reg <= '0;
            enable_reg      <= 1'b0;
            res_write_reg   <= 1'b0;
            res_rs_reg      <= 1'b0;
            res_pulse_reg   <= 1'b0;
            res_status_reg  <= STATUS_NONE;
        end
        else
        begin
            op_reg          <= op_next;
            operational_reg <= operational_next;
            init_ticks_reg  <= init_ticks_next;
            kind_reg        <= kind_next;
            busy_reg        <= busy_next;
            phase_reg       <= phase_next;
            char_count_reg  <= char_count_next;
            char_index_reg  <= char_index_next;
            bit_cnt_reg     <= bit_cnt_next;
            digit_count_reg <= digit_count_next;
            enable_reg      <= enable_next;
            res_write_reg   <= res_write_next;
            res_rs_reg      <= res_rs_next;
            res_pulse_reg   <= res_pulse_next;
            res_status_reg  <= res_status_next;
        end
    end

    assign res.bus_write       = res_write_reg;
    assign res.register_select = res_rs_reg;
    assign res.bus_byte        = res_byte_reg;
    assign res.enable_pulsed   = res_pulse_reg;
    assign res.enable_level    = enable_reg;
    assign res.busy            = busy_reg;
    assign res.operational     = operational_reg;
    assign res.status          = res_status_reg;

    a_busy_needs_operational: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> operational_reg)
        else $error("request busy before init finished");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.digit_emit |-> (digit_count_reg != '0))
        else $error("digit emitted with empty digit buffer");

    a_index_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        char_index_reg <= char_count_reg)
        else $error("string read index past loaded characters");

endmodule

@@ design/char_lcd_tick_sequencer.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        request    in_valid / in_stall        operation, value, last_char
// out       result     out_valid / out_stall      bus_write .. request_status
// cfg       apb write  psel, penable, pwrite      paddr, pwdata, prdata
//
// one request in, one result out
// a number conversion tick runs the one-bit-per-cycle bcd shift loop, then
// strips the leading zero digits
// reset clears the sequencer and the counters and sets the mode to its defaults; no clearing pass
// the next request is taken while a result waits on out_stall

module char_lcd_tick_sequencer
    import clts_pkg::*;
#(
    parameter int STRING_DEPTH     = 32,
    parameter int INIT_DELAY_TICKS = 30
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [VALUE_W-1:0]    value,
    input  logic                  last_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  bus_write,
    output logic                  register_select,
    output logic [7:0]            bus_byte,
    output logic                  enable_pulsed,
    output logic                  enable_level,
    output logic                  busy_res,
    output logic                  operational,
    output logic [1:0]            request_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ctl_word_t ctl;
    dp_flags_t flags;
    cfg_t      cfg;
    res_t      res;
    res_t      out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      out_blocked;
    logic      out_load;

    clts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clts_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .out_blocked (out_blocked),
        .flags       (flags),
        .ctl         (ctl)
    );

    clts_dp #(
        .STRING_DEPTH     (STRING_DEPTH),
        .INIT_DELAY_TICKS (INIT_DELAY_TICKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .operation (operation),
        .value     (value),
        .last_char (last_char),
        .flags     (flags),
        .res       (res)
    );

    assign in_stall       = ~ctl.accept;
    assign out_blocked    = out_valid_reg & out_stall;
    assign out_load       = ctl.out_write & ~out_blocked;
    assign out_valid_next = out_load | out_blocked;

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign bus_write       = out_reg.bus_write;
    assign register_select = out_reg.register_select;
    assign bus_byte        = out_reg.bus_byte;
    assign enable_pulsed   = out_reg.enable_pulsed;
    assign enable_level    = out_reg.enable_level;
    assign busy_res        = out_reg.busy;
    assign operational     = out_reg.operational;
    assign request_status  = out_reg.status;

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_load)
        else $error("result written in the cycle after a request was taken");

    a_out_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
        else $error("stalled result changed or dropped");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result written without raising out_valid");

endmodule

@@ tb/char_lcd_tick_sequencer_checker.sv @@
`timescale 1ns / 1ps

module char_lcd_tick_sequencer_checker
    import clts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [VALUE_W-1:0]    value,
    input  logic                  last_char,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  bus_write,
    input  logic                  register_select,
    input  logic [7:0]            bus_byte,
    input  logic                  enable_pulsed,
    input  logic                  enable_level,
    input  logic                  busy_res,
    input  logic                  operational,
    input  logic [1:0]            request_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    error_count,
    output int                    outstanding,
    output int                    results_checked
);

    localparam int STRING_DEPTH     = 32;
    localparam int INIT_DELAY_TICKS = 30;

    cfg_t        lcd_cfg;
    logic        lcd_ready;
    int unsigned boot_ticks;
    kind_t       job_kind;
    logic        job_busy;
    logic [2:0]  job_phase;
    logic [7:0]  text_buf [STRING_DEPTH];
    int unsigned text_len;
    int unsigned text_pos;
    logic [63:0] number_left;
    logic [3:0]  digit_buf [MAX_DIGITS];
    int unsigned digit_left;
    logic        enable_pin;

    res_t pending_lcd_results [$];

    task automatic put_command(inout res_t r, input logic [7:0] b);
        r.bus_write       = 1'b1;
        r.register_select = 1'b0;
        r.bus_byte        = b;
        r.enable_pulsed   = 1'b0;
        enable_pin        = 1'b1;
    endtask

    task automatic put_data(inout res_t r, input logic [7:0] b);
        r.bus_write       = 1'b1;
        r.register_select = 1'b1;
        r.bus_byte        = b;
        r.enable_pulsed   = 1'b1;
        enable_pin        = 1'b0;
    endtask

    task automatic close_job();
        job_busy   = 1'b0;
        job_kind   = KIND_NONE;
        job_phase  = '0;
        text_len   = 0;
        text_pos   = 0;
        digit_left = 0;
    endtask

    task automatic lcd_step(input logic [1:0] op, input logic [63:0] val, input logic lc,
                            output res_t r);
        int unsigned off;
        int unsigned c;
        logic [63:0] n;
        r = '0;
        if (op == OP_TICK)
        begin
            if (!lcd_ready)
            begin
                if (boot_ticks >= INIT_DELAY_TICKS)
                begin
                    off = boot_ticks - INIT_DELAY_TICKS;
                    case (off)
                        OFF_HOME:  put_command(r, CMD_HOME);
                        OFF_FUNC:  put_command(r, CMD_FUNC_BASE | {4'b0, lcd_cfg.two_lines, 3'b0}
                                               | {5'b0, lcd_cfg.large_font, 2'b0});
                        OFF_DISP:  put_command(r, CMD_DISP_BASE | {5'b0, lcd_cfg.display_on, 2'b0}
                                               | {6'b0, lcd_cfg.cursor_on, 1'b0}
                                               | {7'b0, lcd_cfg.cursor_blink});
                        OFF_CLEAR: put_command(r, CMD_CLEAR);
                        OFF_ENTRY: put_command(r, CMD_ENTRY);
                        OFF_HOME_LOW, OFF_FUNC_LOW, OFF_DISP_LOW, OFF_CLEAR_LOW:
                            enable_pin = 1'b0;
                        OFF_DONE:
                        begin
                            enable_pin = 1'b0;
                            lcd_ready  = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (!lcd_ready)
                    boot_ticks++;
            end
            else if (job_busy)
            begin
                case (job_kind)
                    KIND_STRING:
                    begin
                        if (text_pos < text_len && text_pos < STRING_DEPTH)
                        begin
                            put_data(r, text_buf[text_pos]);
                            text_pos++;
                        end
                        else
                            close_job();
                    end
                    KIND_CLEAR:
                    begin
                        if (job_phase == CLEAR_PH_CMD)
                            put_command(r, CMD_CLEAR);
                        else if (job_phase == CLEAR_PH_LOW)
                            enable_pin = 1'b0;
                        if (job_phase >= CLEAR_PH_LAST)
                            close_job();
                        else
                            job_phase++;
                    end
                    KIND_NUMBER:
                    begin
                        if (job_phase == NUM_PH_CONVERT)
                        begin
                            n = number_left;
                            c = 0;
                            do
                            begin
                                digit_buf[c] = 4'(n % 10);
                                n = n / 10;
                                c++;
                            end while (n != 0 && c < MAX_DIGITS);
                            digit_left  = c;
                            number_left = n;
                            job_phase   = NUM_PH_EMIT;
                        end
                        else if (job_phase == NUM_PH_EMIT)
                        begin
                            if (digit_left > 0 && digit_left <= MAX_DIGITS)
                            begin
                                put_data(r, ASCII_ZERO + {4'b0, digit_buf[digit_left-1]});
                                digit_left--;
                            end
                            else
                                digit_left = 0;
                            if (digit_left == 0)
                                job_phase = NUM_PH_END;
                        end
                        else
                        begin
                            number_left = '0;
                            close_job();
                        end
                    end
                    default: close_job();
                endcase
            end
        end
        else if (!lcd_ready || job_busy)
            r.status = STATUS_REJECTED;
        else
        begin
            r.status = STATUS_ACCEPTED;
            case (op)
                OP_CHAR:
                begin
                    if (text_len < STRING_DEPTH)
                    begin
                        text_buf[text_len] = val[7:0];
                        text_len++;
                    end
                    if (lc)
                    begin
                        job_kind  = KIND_STRING;
                        job_busy  = 1'b1;
                        text_pos  = 0;
                        job_phase = '0;
                    end
                end
                OP_CLEAR:
                begin
                    close_job();
                    job_kind = KIND_CLEAR;
                    job_busy = 1'b1;
                end
                default:
                begin
                    close_job();
                    number_left = val;
                    job_kind    = KIND_NUMBER;
                    job_busy    = 1'b1;
                end
            endcase
        end
        r.enable_level = enable_pin;
        r.busy         = job_busy;
        r.operational  = lcd_ready;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t predicted;
        res_t oldest;
        if (!rst_n)
        begin
            lcd_cfg     = '{two_lines: 1'b1, large_font: 1'b0, display_on: 1'b1,
                            cursor_on: 1'b0, cursor_blink: 1'b0};
            lcd_ready   = 1'b0;
            boot_ticks  = 0;
            job_kind    = KIND_NONE;
            job_busy    = 1'b0;
            job_phase   = '0;
            text_len    = 0;
            text_pos    = 0;
            number_left = '0;
            digit_left  = 0;
            enable_pin  = 1'b0;
            pending_lcd_results.delete();
            error_count     = 0;
            results_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TWO_LINES:    lcd_cfg.two_lines    = pwdata[0];
                    REG_LARGE_FONT:   lcd_cfg.large_font   = pwdata[0];
                    REG_DISPLAY_ON:   lcd_cfg.display_on   = pwdata[0];
                    REG_CURSOR_ON:    lcd_cfg.cursor_on    = pwdata[0];
                    REG_CURSOR_BLINK: lcd_cfg.cursor_blink = pwdata[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                lcd_step(operation, value, last_char, predicted);
                pending_lcd_results.push_back(predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_lcd_results.size() == 0)
                begin
                    $display("%0t: result with no request pending, actual byte %0h status %0h",
                             $time, bus_byte, request_status);
                    error_count++;
                end
                else
                begin
                    oldest = pending_lcd_results.pop_front();
                    check_field("bus_write", oldest.bus_write, bus_write);
                    check_field("register_select", oldest.register_select, register_select);
                    check_field("bus_byte", oldest.bus_byte, bus_byte);
                    check_field("enable_pulsed", oldest.enable_pulsed, enable_pulsed);
                    check_field("enable_level", oldest.enable_level, enable_level);
                    check_field("busy_res", oldest.busy, busy_res);
                    check_field("operational", oldest.operational, operational);
                    check_field("request_status", oldest.status, request_status);
                    results_checked++;
                end
            end
            outstanding = pending_lcd_results.size();
        end
    end

endmodule

@@ tb/char_lcd_tick_sequencer_test.sv @@
`timescale 1ns / 1ps

module char_lcd_tick_sequencer_test;
    import clts_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            operation;
    logic [VALUE_W-1:0]    value;
    logic                  last_char;
    logic                  out_valid;
    logic                  out_stall;
    logic                  bus_write;
    logic                  register_select;
    logic [7:0]            bus_byte;
    logic                  enable_pulsed;
    logic                  enable_level;
    logic                  busy_res;
    logic                  operational;
    logic [1:0]            request_status;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int error_count;
    int outstanding;
    int results_checked;

    int sent_count;
    int burst_left;
    int string_jobs;
    int clear_jobs;
    int number_jobs;
    int noise_bursts;

    char_lcd_tick_sequencer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .value           (value),
        .last_char       (last_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bus_write       (bus_write),
        .register_select (register_select),
        .bus_byte        (bus_byte),
        .enable_pulsed   (enable_pulsed),
        .enable_level    (enable_level),
        .busy_res        (busy_res),
        .operational     (operational),
        .request_status  (request_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    char_lcd_tick_sequencer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .value           (value),
        .last_char       (last_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bus_write       (bus_write),
        .register_select (register_select),
        .bus_byte        (bus_byte),
        .enable_pulsed   (enable_pulsed),
        .enable_level    (enable_level),
        .busy_res        (busy_res),
        .operational     (operational),
        .request_status  (request_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [63:0] val, input logic lc);
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        last_char <= lc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 16);
        end
    endtask

    task automatic send_tick();
        send_request(OP_TICK, rand_value(), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_register(input logic [2:0] idx, input logic bit_value);
        logic [APB_DATA_W-1:0] data;
        data    = $urandom;
        data[0] = bit_value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input cfg_t c);
        write_register(REG_TWO_LINES, c.two_lines);
        write_register(REG_LARGE_FONT, c.large_font);
        write_register(REG_DISPLAY_ON, c.display_on);
        write_register(REG_CURSOR_ON, c.cursor_on);
        write_register(REG_CURSOR_BLINK, c.cursor_blink);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (150)
            @(negedge clk);
    endtask

    initial
    begin : receiver
        int cyc;
        int hold;
        int pattern;
        out_stall = 1'b0;
        cyc       = 0;
        hold      = 0;
        pattern   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 97 == 0)
                pattern = $urandom_range(0, 3);
            // long hold-off so the block backs up into the request side
            if (cyc == 3000)
                hold = 600;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (pattern)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        cfg_t        setting;
        logic [63:0] num;
        logic [63:0] rest;
        logic [1:0]  op_pick;
        int          len;
        int          ticks;
        int          digits;
        int          pick;
        int          phase;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_TICK;
        value      = '0;
        last_char  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        sent_count = 0;
        burst_left = 4;
        string_jobs  = 0;
        clear_jobs   = 0;
        number_jobs  = 0;
        noise_bursts = 0;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        setting = cfg_t'($urandom_range(0, 31));
        apply_setting(setting);

        // requests during init are rejected
        send_request(OP_CHAR, rand_value(), 1'b1);
        send_request(OP_CLEAR, rand_value(), 1'b0);
        send_request(OP_NUMBER, rand_value(), 1'b1);
        repeat (41)
            send_tick();
        send_tick();
        // zero, plus a request while busy
        send_request(OP_NUMBER, 64'd0, 1'b0);
        send_request(OP_CHAR, rand_value(), 1'b1);
        repeat (3)
            send_tick();
        send_request(OP_NUMBER, '1, 1'b0);
        repeat (22)
            send_tick();
        send_request(OP_NUMBER, 64'd10000000000000000000, 1'b1);
        repeat (22)
            send_tick();
        send_request(OP_CLEAR, rand_value(), 1'b1);
        repeat (5)
            send_tick();
        send_request(OP_CHAR, 64'h0, 1'b0);
        send_request(OP_CHAR, '1, 1'b1);
        repeat (3)
            send_tick();
        // partial strings dropped by clear and by number
        send_request(OP_CHAR, rand_value(), 1'b0);
        send_request(OP_CLEAR, rand_value(), 1'b0);
        repeat (5)
            send_tick();
        send_request(OP_CHAR, rand_value(), 1'b0);
        send_request(OP_NUMBER, 64'd9, 1'b0);
        repeat (3)
            send_tick();

        phase = 0;
        while (sent_count < 1150)
        begin
            if (phase < 2 && sent_count >= 400 * (phase + 1))
            begin
                wait_drained();
                setting = (phase == 0) ? '1 : '0;
                apply_setting(setting);
                phase++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_request(OP_CHAR, rand_value(), (i == len - 1));
                ticks = ((len > 32) ? 32 : len) + 1;
                string_jobs++;
            end
            else if (pick < 60)
            begin
                send_request(OP_CLEAR, rand_value(), 1'($urandom_range(0, 1)));
                ticks = 5;
                clear_jobs++;
            end
            else if (pick < 85)
            begin
                num = rand_value() >> $urandom_range(0, 63);
                if ($urandom_range(0, 9) == 0)
                    num = '0;
                send_request(OP_NUMBER, num, 1'($urandom_range(0, 1)));
                digits = 1;
                rest   = num / 10;
                while (rest != 0)
                begin
                    digits++;
                    rest = rest / 10;
                end
                ticks = digits + 2;
                number_jobs++;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    op_pick = 2'($urandom_range(0, 3));
                    send_request(op_pick, rand_value(), 1'($urandom_range(0, 1)));
                end
                ticks = $urandom_range(0, 6);
                noise_bursts++;
            end
            // cut some jobs short so the next request meets a busy block
            if ($urandom_range(0, 9) == 0)
                ticks = $urandom_range(0, ticks);
            repeat (ticks)
                send_tick();
        end

        wait_drained();
        $display("sent %0d requests: %0d strings, %0d clears, %0d numbers, %0d noise bursts",
                 sent_count, string_jobs, clear_jobs, number_jobs, noise_bursts);
        $display("%0d results compared, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
